FILE: rtl/core/vtss_pkg.sv
`default_nettype none

package vtss_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_SINGLE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_DOUBLE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP            = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_DEFAULT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_DEFAULT = 3'd4;

    // Reset values of the configuration registers
    localparam logic [23:0] HOLD_SINGLE_RST    = 24'd150;
    localparam logic [23:0] HOLD_DOUBLE_RST    = 24'd100;
    localparam logic [23:0] GAP_RST            = 24'd120;
    localparam logic [23:0] SETTLE_DEFAULT_RST = 24'd400;
    localparam logic [23:0] TIMEOUT_DEFAULT_RST = 24'd90000;

    // Item commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_POLL  = 1'b1;

    // Condition kinds
    localparam logic [2:0] COND_NONE    = 3'd0;
    localparam logic [2:0] COND_TEXT    = 3'd1;
    localparam logic [2:0] COND_GONE    = 3'd2;
    localparam logic [2:0] COND_LAMP    = 3'd3;
    localparam logic [2:0] COND_ELAPSED = 3'd4;

    // Key events
    localparam logic [1:0] KEY_NONE    = 2'd0;
    localparam logic [1:0] KEY_PRESS   = 2'd1;
    localparam logic [1:0] KEY_RELEASE = 2'd2;

    // Step status
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_MET      = 3'd1;
    localparam logic [2:0] ST_ADVISORY = 3'd2;
    localparam logic [2:0] ST_FAILED   = 3'd3;
    localparam logic [2:0] ST_NO_STEP  = 3'd4;

    typedef struct packed {
        logic        command;
        logic [31:0] now_ms;
        logic        is_tap;
        logic        double_tap;
        logic [23:0] hold_override_ms;
        logic [23:0] settle_time;
        logic [23:0] verify_window;
        logic [23:0] step_timeout;
        logic [2:0]  cond_kind;
        logic [23:0] wait_ms;
        logic        observed;
        logic        obs_fresh;
    } item_t;

    typedef struct packed {
        logic [23:0] hold_single_ms;
        logic [23:0] hold_double_ms;
        logic [23:0] gap_ms;
        logic [23:0] settle_default_ms;
        logic [23:0] timeout_default_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0] key_event;
        logic [2:0] status;
        logic       retapped;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/vtss_engine.sv
`default_nettype none

module vtss_engine
    import vtss_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire cfg_t    cfg,
    input  wire item_t   item,
    input  wire logic    advance,
    output result_t      result
);

    localparam int SUM_W = ((TIME_WIDTH > 24) ? TIME_WIDTH : 24) + 1;

    // Phase codes
    localparam logic [2:0] PH_ACT      = 3'd0;
    localparam logic [2:0] PH_HELD     = 3'd1;
    localparam logic [2:0] PH_GAP      = 3'd2;
    localparam logic [2:0] PH_SETTLING = 3'd3;
    localparam logic [2:0] PH_POLL     = 3'd4;

    // now plus a duration, clamped at the largest time value
    function automatic logic [TIME_WIDTH-1:0] add_sat(
        input logic [TIME_WIDTH-1:0] t,
        input logic [23:0]           d
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(t) + SUM_W'(d);
        if (s[SUM_W-1:TIME_WIDTH] != '0) begin
            return '1;
        end
        return s[TIME_WIDTH-1:0];
    endfunction

    // Step control state
    logic                  step_active_reg, step_active_next;
    logic [2:0]            phase_reg, phase_next;
    logic [1:0]            taps_reg, taps_next;
    logic [1:0]            absent_reg, absent_next;
    logic [TIME_WIDTH-1:0] phase_until_reg, phase_until_next;
    logic [TIME_WIDTH-1:0] verify_until_reg, verify_until_next;
    logic [TIME_WIDTH-1:0] deadline_reg, deadline_next;
    logic [TIME_WIDTH-1:0] wait_base_reg, wait_base_next;

    // Latched step fields
    logic        f_tap_reg, f_double_reg;
    logic [23:0] f_hold_reg, f_settle_reg, f_verify_reg, f_timeout_reg, f_wait_reg;
    logic [2:0]  f_cond_reg;

    // Item time, taken modulo the time width
    logic [TIME_WIDTH+31:0] now_wide;
    logic [TIME_WIDTH-1:0]  now;
    assign now_wide = {{TIME_WIDTH{1'b0}}, item.now_ms};
    assign now      = now_wide[TIME_WIDTH-1:0];

    // Fields as a start item would latch them
    logic [2:0]  start_cond;
    logic [23:0] start_timeout;
    logic [23:0] start_hold;
    always_comb begin
        start_cond = (item.cond_kind > COND_ELAPSED) ? COND_NONE : item.cond_kind;
        start_timeout = (item.is_tap && start_cond != COND_NONE && item.step_timeout == '0)
                        ? cfg.timeout_default_ms : item.step_timeout;
        start_hold = (item.hold_override_ms != '0) ? item.hold_override_ms
                   : (item.double_tap ? cfg.hold_double_ms : cfg.hold_single_ms);
    end

    logic [23:0] stored_hold;
    logic [23:0] settle_eff;
    assign stored_hold = (f_hold_reg != '0) ? f_hold_reg
                       : (f_double_reg ? cfg.hold_double_ms : cfg.hold_single_ms);
    assign settle_eff  = (f_settle_reg != '0) ? f_settle_reg : cfg.settle_default_ms;

    // Time targets, all from the item's time
    logic [TIME_WIDTH-1:0] t_limit, t_press_start, t_press_stored;
    logic [TIME_WIDTH-1:0] t_gap, t_settle, t_window_end;
    assign t_limit        = add_sat(now, start_timeout);
    assign t_press_start  = add_sat(now, start_hold);
    assign t_press_stored = add_sat(now, stored_hold);
    assign t_gap          = add_sat(now, cfg.gap_ms);
    assign t_settle       = add_sat(now, settle_eff);
    assign t_window_end   = add_sat(now, f_verify_reg);

    logic                  phase_due;
    logic [1:0]            taps_dec;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [1:0]            streak_inc;
    assign phase_due  = (now >= phase_until_reg);
    assign taps_dec   = (taps_reg != '0) ? taps_reg - 2'd1 : taps_reg;
    assign streak_inc = (absent_reg < 2'd2) ? absent_reg + 2'd1 : absent_reg;

    // Next state and result of the item in the input register
    logic judge, decided, met;
    logic [TIME_WIDTH-1:0] base_eff;
    always_comb begin
        step_active_next  = step_active_reg;
        phase_next        = phase_reg;
        taps_next         = taps_reg;
        absent_next       = absent_reg;
        phase_until_next  = phase_until_reg;
        verify_until_next = verify_until_reg;
        deadline_next     = deadline_reg;
        wait_base_next    = wait_base_reg;
        result            = '{key_event: KEY_NONE, status: ST_BUSY, retapped: 1'b0};
        judge             = 1'b0;
        decided           = 1'b0;
        met               = 1'b0;
        base_eff          = wait_base_reg;
        elapsed           = now - base_eff;

        if (item.command == CMD_START) begin
            step_active_next = 1'b1;
            absent_next      = '0;
            deadline_next    = t_limit;
            if (item.is_tap) begin
                taps_next        = item.double_tap ? 2'd2 : 2'd1;
                phase_next       = PH_HELD;
                phase_until_next = t_press_start;
                result.key_event = KEY_PRESS;
            end else begin
                phase_next     = PH_POLL;
                wait_base_next = now;
            end
        end else if (!step_active_reg) begin
            result.status = ST_NO_STEP;
        end else begin
            case (phase_reg)
                PH_HELD: begin
                    if (phase_due) begin
                        result.key_event = KEY_RELEASE;
                        taps_next        = taps_dec;
                        if (taps_dec != '0) begin
                            phase_next       = PH_GAP;
                            phase_until_next = t_gap;
                        end else if (f_cond_reg == COND_NONE) begin
                            step_active_next = 1'b0;
                            result.status    = ST_MET;
                        end else begin
                            phase_next        = PH_SETTLING;
                            phase_until_next  = t_settle;
                            verify_until_next = t_window_end;
                        end
                    end
                end
                PH_GAP: begin
                    if (phase_due) begin
                        phase_next       = PH_HELD;
                        phase_until_next = t_press_stored;
                        result.key_event = KEY_PRESS;
                    end
                end
                PH_SETTLING: begin
                    if (phase_due) begin
                        phase_next     = PH_POLL;
                        wait_base_next = now;
                        base_eff       = now;
                        judge          = 1'b1;
                    end
                end
                default: begin
                    judge = 1'b1;
                end
            endcase

            elapsed = now - base_eff;

            // Judge the condition
            if (judge) begin
                case (f_cond_reg)
                    COND_NONE: begin
                        decided = 1'b1;
                        met     = 1'b1;
                    end
                    COND_TEXT: begin
                        decided = item.obs_fresh;
                        met     = item.observed;
                    end
                    COND_GONE: begin
                        decided = item.obs_fresh;
                        if (item.obs_fresh) begin
                            if (item.observed) begin
                                absent_next = '0;
                                met         = 1'b0;
                            end else begin
                                absent_next = streak_inc;
                                met         = (streak_inc >= 2'd2);
                            end
                        end
                    end
                    COND_LAMP: begin
                        decided = 1'b1;
                        met     = item.observed;
                    end
                    default: begin
                        decided = 1'b1;
                        met     = (SUM_W'(elapsed) >= SUM_W'(f_wait_reg));
                    end
                endcase

                if (decided && met) begin
                    step_active_next = 1'b0;
                    result.status    = ST_MET;
                end else if (decided && f_timeout_reg != '0 && now >= deadline_reg) begin
                    step_active_next = 1'b0;
                    result.status    = f_tap_reg ? ST_FAILED : ST_ADVISORY;
                end else if (decided && f_tap_reg && now >= verify_until_reg) begin
                    // verify window closed: tap again
                    taps_next        = f_double_reg ? 2'd2 : 2'd1;
                    absent_next      = '0;
                    phase_next       = PH_HELD;
                    phase_until_next = t_press_stored;
                    result.key_event = KEY_PRESS;
                    result.retapped  = 1'b1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_active_reg  <= 1'b0;
            phase_reg        <= PH_POLL;
            taps_reg         <= '0;
            absent_reg       <= '0;
            phase_until_reg  <= '0;
            verify_until_reg <= '0;
            deadline_reg     <= '0;
            wait_base_reg    <= '0;
        end else if (advance) begin
            step_active_reg  <= step_active_next;
            phase_reg        <= phase_next;
            taps_reg         <= taps_next;
            absent_reg       <= absent_next;
            phase_until_reg  <= phase_until_next;
            verify_until_reg <= verify_until_next;
            deadline_reg     <= deadline_next;
            wait_base_reg    <= wait_base_next;
        end
    end

    // Step fields, latched by a start item
    always_ff @(posedge aclk) begin
        if (advance && item.command == CMD_START) begin
            f_tap_reg     <= item.is_tap;
            f_double_reg  <= item.double_tap;
            f_hold_reg    <= item.hold_override_ms;
            f_settle_reg  <= item.settle_time;
            f_verify_reg  <= item.verify_window;
            f_timeout_reg <= start_timeout;
            f_cond_reg    <= start_cond;
            f_wait_reg    <= item.wait_ms;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/verified_tap_step_sequencer_top.sv
`default_nettype none

// Channel   Ports                              Width  Item
// s_        s_tvalid s_tready s_tdata s_tuser  160+1  step start or poll
// m_        m_tvalid m_tready m_tdata          8      key event, status, retap flag
// cfg_      cfg_valid cfg_ready cfg_index      3+24   configuration register write
//           cfg_data
//
// One item per cycle unless the result stalls; an item passes the input
// register, then the result register fed by the step logic.
// Synchronous active-low reset; no clearing pass, the block is ready at once.
// A stalled result holds the result register; the input register still takes
// one more item, and s_tready falls only when both are full.
// cfg_ready is always high.

module verified_tap_step_sequencer_top
    import vtss_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // now_ms[31:0] is_tap[32] double_tap[33] hold_override_ms[57:34]
    // settle_time[81:58] verify_window[105:82] step_timeout[129:106]
    // cond_kind[132:130] wait_ms[156:133] observed[157] obs_fresh[158], zero[159]
    input  wire logic [159:0]           s_tdata,
    // command[0]
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // key_event[1:0] status[4:2] retapped[5], zero[7:6]
    output logic [7:0]                  m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [23:0]            cfg_data
);

    item_t   item_in;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    cfg_t    cfg_reg;
    logic    out_free;
    logic    advance;

    // Unpack the input item
    always_comb begin
        item_in.command          = s_tuser;
        item_in.now_ms           = s_tdata[31:0];
        item_in.is_tap           = s_tdata[32];
        item_in.double_tap       = s_tdata[33];
        item_in.hold_override_ms = s_tdata[57:34];
        item_in.settle_time      = s_tdata[81:58];
        item_in.verify_window    = s_tdata[105:82];
        item_in.step_timeout     = s_tdata[129:106];
        item_in.cond_kind        = s_tdata[132:130];
        item_in.wait_ms          = s_tdata[156:133];
        item_in.observed         = s_tdata[157];
        item_in.obs_fresh        = s_tdata[158];
    end

    // Flow control
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= item_in;
        end
    end

    // Step logic
    vtss_engine #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .advance (advance),
        .result  (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.retapped, out_reg.status, out_reg.key_event};

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_single_ms     <= HOLD_SINGLE_RST;
            cfg_reg.hold_double_ms     <= HOLD_DOUBLE_RST;
            cfg_reg.gap_ms             <= GAP_RST;
            cfg_reg.settle_default_ms  <= SETTLE_DEFAULT_RST;
            cfg_reg.timeout_default_ms <= TIMEOUT_DEFAULT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HOLD_SINGLE:     cfg_reg.hold_single_ms     <= cfg_data;
                CFG_HOLD_DOUBLE:     cfg_reg.hold_double_ms     <= cfg_data;
                CFG_GAP:             cfg_reg.gap_ms             <= cfg_data;
                CFG_SETTLE_DEFAULT:  cfg_reg.settle_default_ms  <= cfg_data;
                CFG_TIMEOUT_DEFAULT: cfg_reg.timeout_default_ms <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A retap always presses the key
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.retapped |-> out_reg.key_event == KEY_PRESS)
        else $error("retap without key press");

    // A finished or absent step never presses the key
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.status != ST_BUSY |-> out_reg.key_event != KEY_PRESS)
        else $error("key press with a final status");

    // An item held back by a stalled result stays put in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("held item lost or changed");

    // A result taken by the output side is replaced only by an item in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !in_valid_reg |=> !m_tvalid)
        else $error("result invented");

endmodule

`default_nettype wire

FILE: tb/sv/tap_outcome_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register-write channels of the tap step sequencer,
// keeps a shadow of its step state and checks every result item in order.
module tap_outcome_checker
    import vtss_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [159:0]           s_tdata,
    input  wire logic                   s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [7:0]             m_tdata,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [23:0]            cfg_data,
    output int                          mismatches,
    output int                          outstanding
);

    typedef enum logic [2:0] {
        STAGE_HELD   = 3'd1,
        STAGE_GAP    = 3'd2,
        STAGE_SETTLE = 3'd3,
        STAGE_POLL   = 3'd4
    } stage_e;

    typedef enum logic [1:0] {
        VERDICT_OPEN,
        VERDICT_UNMET,
        VERDICT_MET
    } verdict_e;

    // Shadow registers and step state
    cfg_t        shadow_cfg;
    logic        step_live;
    stage_e      stage;
    logic [1:0]  taps_pending;
    logic [1:0]  absent_run;
    logic [31:0] stage_end;
    logic [31:0] verify_end;
    logic [31:0] deadline_at;
    logic [31:0] wait_from;
    item_t       step;

    result_t     outcome_q[$];
    result_t     want;
    result_t     predicted;
    item_t       seen;

    // now + duration, clamped at the top of the time range
    function automatic logic [31:0] sat_add(input logic [31:0] base, input logic [23:0] dur);
        logic [32:0] sum;
        sum = {1'b0, base} + {9'd0, dur};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    task automatic begin_hold(input logic [31:0] now);
        logic [23:0] hold;
        if (step.hold_override_ms != 24'd0)
            hold = step.hold_override_ms;
        else if (step.double_tap)
            hold = shadow_cfg.hold_double_ms;
        else
            hold = shadow_cfg.hold_single_ms;
        stage     = STAGE_HELD;
        stage_end = sat_add(now, hold);
    endtask

    task automatic predict_step_outcome(input item_t it, output result_t r);
        logic        judge;
        verdict_e    verdict;
        logic [31:0] now;
        logic [2:0]  kind;
        now         = it.now_ms;
        r.key_event = KEY_NONE;
        r.status    = ST_BUSY;
        r.retapped  = 1'b0;
        judge       = 1'b0;
        verdict     = VERDICT_OPEN;

        if (it.command == CMD_START) begin
            // latch the step and act at once
            step = it;
            kind = it.cond_kind;
            if (kind > COND_ELAPSED) kind = COND_NONE;
            step.cond_kind = kind;
            if (it.is_tap && kind != COND_NONE && it.step_timeout == 24'd0)
                step.step_timeout = shadow_cfg.timeout_default_ms;
            step_live   = 1'b1;
            absent_run  = 2'd0;
            deadline_at = sat_add(now, step.step_timeout);
            if (it.is_tap) begin
                taps_pending = it.double_tap ? 2'd2 : 2'd1;
                begin_hold(now);
                r.key_event = KEY_PRESS;
            end else begin
                stage     = STAGE_POLL;
                wait_from = now;
            end
        end else if (!step_live) begin
            r.status = ST_NO_STEP;
        end else begin
            case (stage)
                STAGE_HELD: begin
                    if (now >= stage_end) begin
                        r.key_event = KEY_RELEASE;
                        if (taps_pending != 2'd0) taps_pending = taps_pending - 2'd1;
                        if (taps_pending != 2'd0) begin
                            stage     = STAGE_GAP;
                            stage_end = sat_add(now, shadow_cfg.gap_ms);
                        end else if (step.cond_kind == COND_NONE) begin
                            step_live = 1'b0;
                            r.status  = ST_MET;
                        end else begin
                            stage      = STAGE_SETTLE;
                            stage_end  = sat_add(now, (step.settle_time != 24'd0) ?
                                                 step.settle_time :
                                                 shadow_cfg.settle_default_ms);
                            verify_end = sat_add(now, step.verify_window);
                        end
                    end
                end
                STAGE_GAP: begin
                    if (now >= stage_end) begin
                        begin_hold(now);
                        r.key_event = KEY_PRESS;
                    end
                end
                STAGE_SETTLE: begin
                    if (now >= stage_end) begin
                        stage     = STAGE_POLL;
                        wait_from = now;
                        judge     = 1'b1;
                    end
                end
                default: judge = 1'b1;
            endcase

            if (judge) begin
                case (step.cond_kind)
                    COND_NONE: verdict = VERDICT_MET;
                    COND_TEXT: begin
                        if (!it.obs_fresh)
                            verdict = VERDICT_OPEN;
                        else
                            verdict = it.observed ? VERDICT_MET : VERDICT_UNMET;
                    end
                    COND_GONE: begin
                        // needs two absent fresh reads in a row
                        if (!it.obs_fresh) begin
                            verdict = VERDICT_OPEN;
                        end else if (it.observed) begin
                            absent_run = 2'd0;
                            verdict    = VERDICT_UNMET;
                        end else begin
                            if (absent_run < 2'd2) absent_run = absent_run + 2'd1;
                            verdict = (absent_run >= 2'd2) ? VERDICT_MET : VERDICT_UNMET;
                        end
                    end
                    COND_LAMP: verdict = it.observed ? VERDICT_MET : VERDICT_UNMET;
                    default: begin
                        verdict = ((now - wait_from) >= {8'd0, step.wait_ms}) ?
                                  VERDICT_MET : VERDICT_UNMET;
                    end
                endcase

                if (verdict == VERDICT_MET) begin
                    step_live = 1'b0;
                    r.status  = ST_MET;
                end else if (verdict == VERDICT_UNMET && step.step_timeout != 24'd0 &&
                             now >= deadline_at) begin
                    step_live = 1'b0;
                    r.status  = step.is_tap ? ST_FAILED : ST_ADVISORY;
                end else if (verdict == VERDICT_UNMET && step.is_tap && now >= verify_end) begin
                    // verify window closed: tap again
                    taps_pending = step.double_tap ? 2'd2 : 2'd1;
                    absent_run   = 2'd0;
                    begin_hold(now);
                    r.key_event = KEY_PRESS;
                    r.retapped  = 1'b1;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_cfg.hold_single_ms     = HOLD_SINGLE_RST;
            shadow_cfg.hold_double_ms     = HOLD_DOUBLE_RST;
            shadow_cfg.gap_ms             = GAP_RST;
            shadow_cfg.settle_default_ms  = SETTLE_DEFAULT_RST;
            shadow_cfg.timeout_default_ms = TIMEOUT_DEFAULT_RST;
            step_live    = 1'b0;
            stage        = STAGE_POLL;
            taps_pending = 2'd0;
            absent_run   = 2'd0;
            stage_end    = '0;
            verify_end   = '0;
            deadline_at  = '0;
            wait_from    = '0;
            step         = '0;
            outcome_q.delete();
            mismatches   = 0;
        end else begin
            // register writes only arrive while the block is idle
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_HOLD_SINGLE:     shadow_cfg.hold_single_ms     = cfg_data;
                    CFG_HOLD_DOUBLE:     shadow_cfg.hold_double_ms     = cfg_data;
                    CFG_GAP:             shadow_cfg.gap_ms             = cfg_data;
                    CFG_SETTLE_DEFAULT:  shadow_cfg.settle_default_ms  = cfg_data;
                    CFG_TIMEOUT_DEFAULT: shadow_cfg.timeout_default_ms = cfg_data;
                    default: ;
                endcase
            end

            // result side
            if (m_tvalid && m_tready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result item, got tdata %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    if (m_tdata !== {2'b00, want.retapped, want.status, want.key_event}) begin
                        $display("%0t: result mismatch, expected %h (key %0d status %0d %s",
                                 $time, {2'b00, want.retapped, want.status, want.key_event},
                                 want.key_event, want.status, "retap)");
                        $display("%0t:   retap %0d expected, got tdata %h",
                                 $time, want.retapped, m_tdata);
                        mismatches++;
                    end
                end
            end

            // item side
            if (s_tvalid && s_tready) begin
                seen.command          = s_tuser;
                seen.now_ms           = s_tdata[31:0];
                seen.is_tap           = s_tdata[32];
                seen.double_tap       = s_tdata[33];
                seen.hold_override_ms = s_tdata[57:34];
                seen.settle_time      = s_tdata[81:58];
                seen.verify_window    = s_tdata[105:82];
                seen.step_timeout     = s_tdata[129:106];
                seen.cond_kind        = s_tdata[132:130];
                seen.wait_ms          = s_tdata[156:133];
                seen.observed         = s_tdata[157];
                seen.obs_fresh        = s_tdata[158];
                predict_step_outcome(seen, predicted);
                outcome_q.push_back(predicted);
            end
        end
        outstanding = outcome_q.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the tap step sequencer; checking lives in tap_outcome_checker.
module tb_top;
    import vtss_pkg::*;

    localparam int         PHASE_COUNT  = 6;
    localparam int         PHASE_ITEMS  = 290;
    localparam int         QUIET_LIMIT  = 4000;
    localparam logic [2:0] COND_UNKNOWN = 3'd7;

    logic                   aclk      = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [159:0]           s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [23:0]            cfg_data;

    int                     mismatches;
    int                     outstanding;
    int                     send_idle;
    int                     recv_idle = 84;
    int                     sent;
    int                     quiet_cycles;
    int                     target;
    logic [31:0]            guest_now;

    verified_tap_step_sequencer_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tap_outcome_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // watchdog: cycles in which no channel moves anything
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [159:0] pack_item(input item_t it);
        return {1'b0, it.obs_fresh, it.observed, it.wait_ms, it.cond_kind, it.step_timeout,
                it.verify_window, it.settle_time, it.hold_override_ms, it.double_tap,
                it.is_tap, it.now_ms};
    endfunction

    function automatic item_t mk_start(input logic [31:0] now, input logic tap, input logic dbl,
                                       input logic [23:0] hold, input logic [23:0] settle,
                                       input logic [23:0] verify, input logic [23:0] tmo,
                                       input logic [2:0] kind, input logic [23:0] waitv);
        item_t it;
        it                  = '0;
        it.command          = CMD_START;
        it.now_ms           = now;
        it.is_tap           = tap;
        it.double_tap       = dbl;
        it.hold_override_ms = hold;
        it.settle_time      = settle;
        it.verify_window    = verify;
        it.step_timeout     = tmo;
        it.cond_kind        = kind;
        it.wait_ms          = waitv;
        return it;
    endfunction

    function automatic item_t mk_poll(input logic [31:0] now, input logic obs, input logic fresh);
        item_t it;
        it           = '0;
        it.command   = CMD_POLL;
        it.now_ms    = now;
        it.observed  = obs;
        it.obs_fresh = fresh;
        return it;
    endfunction

    // durations: mostly short, sometimes zero, the maximum or any 24-bit value
    function automatic logic [23:0] rand_dur(input int short_max);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)       return 24'hFF_FFFF;
        else if (pick < 7)  return 24'($urandom);
        else if (pick < 32) return 24'd0;
        else                return 24'($urandom_range(1, short_max));
    endfunction

    task automatic push_item(input item_t it);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_item(it);
        s_tuser  <= it.command;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    // hold off the sender until every result item has come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic load_settings(input cfg_t c);
        write_reg(CFG_HOLD_SINGLE, c.hold_single_ms);
        write_reg(CFG_HOLD_DOUBLE, c.hold_double_ms);
        write_reg(CFG_GAP, c.gap_ms);
        write_reg(CFG_SETTLE_DEFAULT, c.settle_default_ms);
        write_reg(CFG_TIMEOUT_DEFAULT, c.timeout_default_ms);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t pick_settings(input int phase_no);
        cfg_t c;
        case (phase_no)
            0, 5: begin
                c.hold_single_ms     = HOLD_SINGLE_RST;
                c.hold_double_ms     = HOLD_DOUBLE_RST;
                c.gap_ms             = GAP_RST;
                c.settle_default_ms  = SETTLE_DEFAULT_RST;
                c.timeout_default_ms = TIMEOUT_DEFAULT_RST;
            end
            1: c = '0;
            3: c = '1;
            default: begin
                c.hold_single_ms     = 24'($urandom_range(1, 300));
                c.hold_double_ms     = 24'($urandom_range(1, 300));
                c.gap_ms             = 24'($urandom_range(0, 300));
                c.settle_default_ms  = 24'($urandom_range(1, 600));
                c.timeout_default_ms = 24'($urandom_range(100, 3000));
            end
        endcase
        return c;
    endfunction

    // guest time mostly creeps forward, with the odd leap, wrap or jump near the top
    task automatic bump_time();
        int pick;
        pick = $urandom_range(0, 999);
        if (pick < 5)       guest_now = $urandom;
        else if (pick < 10) guest_now = 32'hFFFF_FFFF - $urandom_range(0, 500);
        else if (pick < 40) guest_now = guest_now + $urandom_range(0, 3000);
        else                guest_now = guest_now + $urandom_range(0, 60);
    endtask

    task automatic push_random_poll();
        item_t        it;
        logic [159:0] noise;
        bump_time();
        noise        = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it           = noise[$bits(item_t)-1:0];
        it.command   = CMD_POLL;
        it.now_ms    = guest_now;
        it.observed  = ($urandom_range(0, 99) < 30);
        it.obs_fresh = ($urandom_range(0, 99) < 75);
        push_item(it);
    endtask

    // one step start followed by a run of polls; now and then only stray polls
    task automatic run_sequence();
        item_t      it;
        logic [2:0] kind;
        int         polls;
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 4)) push_random_poll();
        end else begin
            bump_time();
            if ($urandom_range(0, 9) < 9) kind = 3'($urandom_range(0, 4));
            else                          kind = 3'($urandom_range(5, 7));
            it = mk_start(guest_now, ($urandom_range(0, 99) < 80), 1'($urandom_range(0, 1)),
                          rand_dur(150), rand_dur(150), rand_dur(300), rand_dur(1500),
                          kind, rand_dur(300));
            it.observed  = 1'($urandom_range(0, 1));
            it.obs_fresh = 1'($urandom_range(0, 1));
            push_item(it);
            polls = $urandom_range(3, 45);
            repeat (polls) push_random_poll();
        end
        if ($urandom_range(0, 29) == 0) drain_results();
    endtask

    task automatic directed_items();
        // poll with no step running
        push_item(mk_poll(32'd0, 1'b0, 1'b0));
        // single tap, no condition, default hold
        push_item(mk_start(32'd100, 1'b1, 1'b0, 24'd0, 24'd0, 24'd0, 24'd0, COND_NONE, 24'd0));
        push_item(mk_poll(32'd200, 1'b0, 1'b0));
        push_item(mk_poll(32'd250, 1'b0, 1'b0));
        // double tap on text: gap, stale read, then retap once the window has closed
        push_item(mk_start(32'd1000, 1'b1, 1'b1, 24'd10, 24'd5, 24'd0, 24'd0, COND_TEXT, 24'd0));
        push_item(mk_poll(32'd1010, 1'b0, 1'b0));
        push_item(mk_poll(32'd1130, 1'b0, 1'b0));
        push_item(mk_poll(32'd1140, 1'b0, 1'b0));
        push_item(mk_poll(32'd1145, 1'b1, 1'b0));
        push_item(mk_poll(32'd1146, 1'b0, 1'b1));
        // text gone: streak broken by a present read, then two absent reads
        push_item(mk_start(32'd2000, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0, 24'd50, COND_GONE, 24'd0));
        push_item(mk_poll(32'd2001, 1'b0, 1'b1));
        push_item(mk_poll(32'd2002, 1'b1, 1'b1));
        push_item(mk_poll(32'd2003, 1'b0, 1'b0));
        push_item(mk_poll(32'd2004, 1'b0, 1'b1));
        push_item(mk_poll(32'd2005, 1'b0, 1'b1));
        // lamp action past its deadline ends as advisory
        push_item(mk_start(32'd3000, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0, 24'd10, COND_LAMP, 24'd0));
        push_item(mk_poll(32'd3020, 1'b0, 1'b0));
        // lamp tap past its deadline fails
        push_item(mk_start(32'd4000, 1'b1, 1'b0, 24'd5, 24'd5, 24'hFF_FFFF, 24'd30, COND_LAMP,
                           24'd0));
        push_item(mk_poll(32'd4005, 1'b0, 1'b0));
        push_item(mk_poll(32'd4010, 1'b0, 1'b0));
        push_item(mk_poll(32'd4040, 1'b0, 1'b0));
        // saturating hold near the top of time
        push_item(mk_start(32'hFFFF_FFF0, 1'b1, 1'b0, 24'hFF_FFFF, 24'd0, 24'd0, 24'd0,
                           COND_NONE, 24'd0));
        push_item(mk_poll(32'hFFFF_FFFF, 1'b1, 1'b1));
        // unknown condition kind counts as none
        push_item(mk_start(32'hFFFF_FFFF, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0, 24'd0, COND_UNKNOWN,
                           24'hFF_FFFF));
        push_item(mk_poll(32'hFFFF_FFFF, 1'b0, 1'b0));
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_START;
        cfg_valid = 1'b0;
        cfg_index = CFG_HOLD_SINGLE;
        cfg_data  = '0;
        send_idle = 38;
        sent      = 0;
        guest_now = '0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed_items();

        for (int phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
            drain_results();
            load_settings(pick_settings(phase_no));
            // receiver-heavy idling, then sender-heavy, then none
            if (phase_no < 2) begin
                send_idle = 38;
                recv_idle = 84;
            end else if (phase_no < 4) begin
                send_idle = 84;
                recv_idle = 38;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            target = sent + PHASE_ITEMS;
            while (sent < target) run_sequence();
        end

        drain_results();
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: verified_tap_step_sequencer_top.f
rtl/core/vtss_pkg.sv
rtl/core/vtss_engine.sv
rtl/core/verified_tap_step_sequencer_top.sv
tb/sv/tap_outcome_checker.sv
tb/sv/tb_top.sv
